// ----- rtl/core/skht_pkg.sv -----
`timescale 1ns / 1ps

package skht_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic                success;
    logic [HANDLE_W-1:0] handle_out;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

// ----- rtl/core/skht_ram.sv -----
`timescale 1ns / 1ps

module skht_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/skht_cmp.sv -----
`timescale 1ns / 1ps

module skht_cmp (
  input  logic [skht_pkg::KEY_W-1:0] stored_key,
  input  logic [skht_pkg::KEY_W-1:0] probe_key,
  output skht_pkg::cmp_t             result
);
  import skht_pkg::*;

  // unsigned magnitude compare of a stored key against the probe
  assign result.gt = (stored_key > probe_key);
  assign result.eq = (stored_key == probe_key);

endmodule

// ----- rtl/core/sorted_key_handle_table_unit.sv -----
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------
// request   | req_valid / req_ready  | req_data: operation, key, handle_in
// response  | rsp_valid / rsp_ready  | rsp_data: success, handle_out
//
// one request at a time; req_ready is high only while the sequencer is idle
// insert: walks down from the hole at count, moving each larger key up one slot
// lookup: scans up from index 0 until a match, a larger key or the table end
// both run on the single table port: one read and one compare per step
// rst (synchronous) empties the table at once; entry contents are not cleared
// a stalled response waits in the output register; the next request is taken

module sorted_key_handle_table_unit #(
  parameter int CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  skht_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output skht_pkg::rsp_t rsp_data
);
  import skht_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_LK_RD,
    S_LK_CMP,
    S_RESP
  } state_t;

  state_t           state;
  req_t             cur;       // request being worked on
  rsp_t             result;    // finished answer waiting for the output register
  logic [CNT_W-1:0] count;     // number of valid entries
  logic [CNT_W-1:0] pos;       // insert hole or lookup scan index

  // table port
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  logic [ENT_W-1:0] rdata_raw;
  entry_t           rdata;
  cmp_t             cmp;
  logic [CNT_W-1:0] pos_dec;

  assign rdata   = entry_t'(rdata_raw);
  assign pos_dec = pos - CNT_W'(1);

  skht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  // one shared comparator for both the insert shift and the lookup scan
  skht_cmp u_cmp (
    .stored_key (rdata.key),
    .probe_key  (cur.key),
    .result     (cmp)
  );

  assign req_ready = (state == S_IDLE);

  // table access for the current step
  always_comb begin
    we    = 1'b0;
    waddr = pos[IDX_W-1:0];
    wdata = '{key: cur.key, handle: cur.handle_in};
    raddr = pos[IDX_W-1:0];
    case (state)
      S_INS_RD: begin
        // hole at the front: the new pair lands there
        if (pos == '0) begin
          we = 1'b1;
        end
        raddr = pos_dec[IDX_W-1:0];
      end
      S_INS_CMP: begin
        // move a larger key up into the hole, or drop the new pair in
        we = 1'b1;
        if (cmp.gt) begin
          wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // output register drained, unless a new response refills it below
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req_data;
            if (req_data.operation == OP_INSERT) begin
              pos <= count;
              if (count == CNT_W'(CAPACITY)) begin
                // table full: nothing stored
                result <= '{success: 1'b0, handle_out: '0};
                state  <= S_RESP;
              end else begin
                state <= S_INS_RD;
              end
            end else begin
              pos   <= '0;
              state <= S_LK_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos == '0) begin
            count  <= count + CNT_W'(1);
            result <= '{success: 1'b1, handle_out: '0};
            state  <= S_RESP;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (cmp.gt) begin
            pos   <= pos_dec;
            state <= S_INS_RD;
          end else begin
            count  <= count + CNT_W'(1);
            result <= '{success: 1'b1, handle_out: '0};
            state  <= S_RESP;
          end
        end
        S_LK_RD: begin
          if (pos == count) begin
            // ran off the end of the table
            result <= '{success: 1'b0, handle_out: '0};
            state  <= S_RESP;
          end else begin
            state <= S_LK_CMP;
          end
        end
        S_LK_CMP: begin
          if (cmp.gt) begin
            // passed where the key would sit
            result <= '{success: 1'b0, handle_out: '0};
            state  <= S_RESP;
          end else if (cmp.eq) begin
            result <= '{success: 1'b1, handle_out: rdata.handle};
            state  <= S_RESP;
          end else begin
            pos   <= pos + CNT_W'(1);
            state <= S_LK_RD;
          end
        end
        S_RESP: begin
          // output register free, or being emptied this cycle
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp_data  <= result;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/skht_checker.sv -----
`timescale 1ns / 1ps

module skht_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input skht_pkg::rsp_t rsp_data
);
  import skht_pkg::*;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped or changed under stall");

  // one request in work at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a response only appears after the block was busy
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response without work");

  // reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("output not cleared by reset");

  // failed responses (misses and a full table) answer with a zero handle
  a_zero_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.success |-> rsp_data.handle_out == '0)
    else $error("failed response carries a handle");

endmodule

bind sorted_key_handle_table_unit skht_checker u_skht_checker (.*);
